[rtl/ftewma_pkg.sv]
// Shared types and constants for the flow totaliser with moving average.
// Used by the interfaces, the update stage, the volume divider and the top level.
// Depends on nothing.
`default_nettype none

package ftewma_pkg;

  // Field widths
  localparam int unsigned RateW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned AccumW = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // Volume scaling: mL = accum / 6000 = (accum >> 4) / 375
  localparam int unsigned VolDivisor  = 6000;
  localparam int unsigned VolPreShift = 4;
  localparam int unsigned VolQuotW    = 16;
  // accum at or above this gives a quotient that no longer fits 16 bits
  localparam logic [AccumW-1:0] VolSatLimit = AccumW'(65536 * VolDivisor);
  // Dividend after the pre-shift, below VolSatLimit >> 4
  localparam int unsigned VolDividendW = 25;
  // ceil(2^33 / 375); exact for every dividend below 2^33 / 283
  localparam int unsigned RecipShift = 33;
  localparam int unsigned RecipW     = 25;
  localparam logic [RecipW-1:0] RecipMul = 25'd22906493;
  localparam int unsigned ProdW      = VolDividendW + RecipW;

  // Configuration register indices
  typedef enum logic [CfgIdxW-1:0] {
    CfgOverRange    = 3'd0,
    CfgMinRate      = 3'd1,
    CfgVolCutoff    = 3'd2,
    CfgLowMinVolume = 3'd3,
    CfgLowMinPeak   = 3'd4,
    CfgLowFallRate  = 3'd5
  } cfg_idx_e;

  // Opcode of an input word
  typedef enum logic {
    OpSample = 1'b0,
    OpClear  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [CfgW-1:0] over_range_limit;
    logic [CfgW-1:0] calibrated_min_rate;
    logic [CfgW-1:0] volume_cutoff_ml;
    logic [CfgW-1:0] lowrate_min_volume_ml;
    logic [CfgW-1:0] lowrate_min_peak;
    logic [CfgW-1:0] lowrate_fall_rate;
  } cfg_t;

  // Running state as shown after one word's update
  typedef struct packed {
    logic [RateW-1:0]  rate_now;
    logic              sample_bad;
    logic [RateW-1:0]  average_rate;
    logic [RateW-1:0]  peak_rate;
    logic [AccumW-1:0] volume_accum;
    logic [CountW-1:0] good_count;
    logic [CountW-1:0] bad_count;
    logic [CountW-1:0] bad_run;
    logic [CountW-1:0] inrange_count;
  } res_t;

endpackage

`default_nettype wire

[rtl/ftewma_if.sv]
// Valid/ready channels for input words and result words.
// Depends on ftewma_pkg for field widths.
`default_nettype none

interface ftewma_in_if;
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic [ftewma_pkg::RateW-1:0]    sample_rate;
  logic                            sample_ok;

  modport source (output valid, output opcode, output sample_rate, output sample_ok,
                  input ready);
  modport sink   (input valid, input opcode, input sample_rate, input sample_ok,
                  output ready);
endinterface

interface ftewma_out_if;
  logic                            valid;
  logic                            ready;
  logic [ftewma_pkg::RateW-1:0]    rate_now;
  logic                            sample_bad;
  logic [ftewma_pkg::RateW-1:0]    average_rate;
  logic [ftewma_pkg::RateW-1:0]    peak_rate;
  logic [ftewma_pkg::AccumW-1:0]   volume_accum;
  logic [ftewma_pkg::VolQuotW-1:0] volume_ml;
  logic [ftewma_pkg::CountW-1:0]   good_count;
  logic [ftewma_pkg::CountW-1:0]   bad_count;
  logic [ftewma_pkg::CountW-1:0]   bad_run;
  logic [ftewma_pkg::CountW-1:0]   inrange_count;
  logic                            cutoff_volume;
  logic                            cutoff_lowrate;

  modport source (output valid, output rate_now, output sample_bad, output average_rate,
                  output peak_rate, output volume_accum, output volume_ml,
                  output good_count, output bad_count, output bad_run,
                  output inrange_count, output cutoff_volume, output cutoff_lowrate,
                  input ready);
  modport sink   (input valid, input rate_now, input sample_bad, input average_rate,
                  input peak_rate, input volume_accum, input volume_ml,
                  input good_count, input bad_count, input bad_run,
                  input inrange_count, input cutoff_volume, input cutoff_lowrate,
                  output ready);
endinterface

`default_nettype wire

[rtl/ftewma_update.sv]
// Running-state update: clamp, integrate, average, peak and counters.
// The state registers double as the result register of this stage.
// Depends on ftewma_pkg.
`default_nettype none

module ftewma_update (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         adv_i,
  input  wire                         opcode_i,
  input  wire [ftewma_pkg::RateW-1:0] sample_rate_i,
  input  wire                         sample_ok_i,
  input  wire ftewma_pkg::cfg_t       cfg_i,
  output ftewma_pkg::res_t            res_o
);

  ftewma_pkg::res_t                state_q, state_d;
  logic [ftewma_pkg::CountW-1:0]   ticks_q, ticks_d;
  logic [ftewma_pkg::CountW-1:0]   ticks_inc;
  logic [ftewma_pkg::CountW-1:0]   good_inc;
  logic [ftewma_pkg::RateW-1:0]    rate_clamp;
  logic [ftewma_pkg::AccumW-1:0]   integ_prod;
  logic [ftewma_pkg::RateW+1:0]    avg_sum;
  logic [ftewma_pkg::RateW-1:0]    avg_new;
  logic                            integrate;

  // Clamp and the datapath terms of a good sample
  always_comb begin
    ticks_inc  = ticks_q + 1'b1;
    good_inc   = state_q.good_count + 1'b1;
    integrate  = (good_inc > 16'd1);
    rate_clamp = (sample_rate_i > cfg_i.over_range_limit) ? cfg_i.over_range_limit
                                                           : sample_rate_i;
    integ_prod = {16'd0, rate_clamp} * {16'd0, ticks_inc};
    avg_sum    = {1'b0, state_q.average_rate, 1'b0} + {2'b00, state_q.average_rate}
               + {2'b00, rate_clamp} + 18'd1;
    avg_new    = avg_sum[ftewma_pkg::RateW+1:2];
  end

  // Next state for the word in the input register
  always_comb begin
    state_d            = state_q;
    ticks_d            = ticks_q;
    state_d.rate_now   = '0;
    state_d.sample_bad = 1'b0;
    if (opcode_i == ftewma_pkg::OpClear) begin
      state_d = '0;
      ticks_d = '0;
    end else if (!sample_ok_i) begin
      ticks_d            = ticks_inc;
      state_d.sample_bad = 1'b1;
      state_d.bad_count  = state_q.bad_count + 1'b1;
      state_d.bad_run    = state_q.bad_run + 1'b1;
    end else begin
      ticks_d            = '0;
      state_d.bad_run    = '0;
      state_d.rate_now   = rate_clamp;
      state_d.good_count = good_inc;
      if (integrate) begin
        state_d.volume_accum = state_q.volume_accum + integ_prod;
        state_d.average_rate = avg_new;
        if (avg_new > state_q.peak_rate) begin
          state_d.peak_rate = avg_new;
        end
        if (rate_clamp >= cfg_i.calibrated_min_rate) begin
          state_d.inrange_count = state_q.inrange_count + 1'b1;
        end
      end
    end
  end

  // Commit when the word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      ticks_q <= '0;
    end else if (adv_i) begin
      state_q <= state_d;
      ticks_q <= ticks_d;
    end
  end

  assign res_o = state_q;

  // The peak only ever follows the average upwards
  a_peak_ge_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.peak_rate >= state_q.average_rate)
    else $error("peak below average");

  // A clear empties the running state
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (opcode_i == ftewma_pkg::OpClear) |=>
      (state_q.volume_accum == '0) && (state_q.good_count == '0) && (ticks_q == '0))
    else $error("state not cleared");

  // A bad sample never carries a rate
  a_bad_no_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.sample_bad |-> (state_q.rate_now == '0))
    else $error("bad sample with rate");

endmodule

`default_nettype wire

[rtl/ftewma_voldiv.sv]
// Accumulator to millilitres: divide by 6000 by reciprocal multiply, saturate.
// One registered multiply; the quotient is valid the cycle after en_i.
// Depends on ftewma_pkg.
`default_nettype none

module ftewma_voldiv (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire [ftewma_pkg::AccumW-1:0]   accum_i,
  output logic [ftewma_pkg::VolQuotW-1:0] vol_ml_o
);

  logic [ftewma_pkg::VolDividendW-1:0] dividend;
  logic [ftewma_pkg::ProdW-1:0]        prod_q;
  logic                                sat_q;

  assign dividend = accum_i[ftewma_pkg::VolPreShift +: ftewma_pkg::VolDividendW];

  // Hold the product and the overflow flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {{ftewma_pkg::RecipW{1'b0}}, dividend} *
                {{ftewma_pkg::VolDividendW{1'b0}}, ftewma_pkg::RecipMul};
      sat_q  <= (accum_i >= ftewma_pkg::VolSatLimit);
    end
  end

  // Saturate at the 16-bit ceiling
  assign vol_ml_o = sat_q ? {ftewma_pkg::VolQuotW{1'b1}}
                          : prod_q[ftewma_pkg::RecipShift +: ftewma_pkg::VolQuotW];

endmodule

`default_nettype wire

[rtl/flow_totalizer_ewma_core.sv]
// Flow totaliser with moving average: top level, four-stage pipeline.
// Each word passes the input, state, volume and output registers in that order.
// Throughput: one word per cycle unless the output stalls; the update is combinational.
// A stalled output backs up through the stages; ready falls only when all are full.
// Reset: asynchronous, active low; clears the running state and sets the
// configuration registers to their defaults. No clearing pass is needed.
`default_nettype none

module flow_totalizer_ewma_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  ftewma_in_if.sink                          item_in_i,
  ftewma_out_if.source                       result_out_o,
  input  wire                                cfg_we_i,
  input  wire [ftewma_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [ftewma_pkg::CfgW-1:0]         cfg_wdata_i
);

  ftewma_pkg::cfg_t                cfg_q;
  logic                            valid_a_q, valid_b_q, valid_c_q, valid_d_q;
  logic                            ready_a, ready_b, ready_c, ready_d;
  logic                            acc_a, adv_b, adv_c, adv_d;
  logic                            opcode_a_q, ok_a_q;
  logic [ftewma_pkg::RateW-1:0]    rate_a_q;
  ftewma_pkg::res_t                res_b, res_c_q, res_d_q;
  logic [ftewma_pkg::VolQuotW-1:0] vol_c;
  logic [ftewma_pkg::VolQuotW-1:0] vol_d_q;
  logic                            cut_vol_q, cut_low_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.over_range_limit      <= 16'hFFFF;
      cfg_q.calibrated_min_rate   <= 16'h0000;
      cfg_q.volume_cutoff_ml      <= 16'hFFFF;
      cfg_q.lowrate_min_volume_ml <= 16'hFFFF;
      cfg_q.lowrate_min_peak      <= 16'hFFFF;
      cfg_q.lowrate_fall_rate     <= 16'h0000;
    end else if (cfg_we_i) begin
      case (ftewma_pkg::cfg_idx_e'(cfg_idx_i))
        ftewma_pkg::CfgOverRange:    cfg_q.over_range_limit      <= cfg_wdata_i;
        ftewma_pkg::CfgMinRate:      cfg_q.calibrated_min_rate   <= cfg_wdata_i;
        ftewma_pkg::CfgVolCutoff:    cfg_q.volume_cutoff_ml      <= cfg_wdata_i;
        ftewma_pkg::CfgLowMinVolume: cfg_q.lowrate_min_volume_ml <= cfg_wdata_i;
        ftewma_pkg::CfgLowMinPeak:   cfg_q.lowrate_min_peak      <= cfg_wdata_i;
        ftewma_pkg::CfgLowFallRate:  cfg_q.lowrate_fall_rate     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Stage handshake: a stage takes a word when empty or when it is passing one on
  assign ready_d = !valid_d_q || result_out_o.ready;
  assign adv_d   = valid_c_q && ready_d;
  assign ready_c = !valid_c_q || ready_d;
  assign adv_c   = valid_b_q && ready_c;
  assign ready_b = !valid_b_q || ready_c;
  assign adv_b   = valid_a_q && ready_b;
  assign ready_a = !valid_a_q || ready_b;
  assign acc_a   = item_in_i.valid && ready_a;

  assign item_in_i.ready = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else begin
      valid_a_q <= acc_a || (valid_a_q && !adv_b);
      valid_b_q <= adv_b || (valid_b_q && !adv_c);
      valid_c_q <= adv_c || (valid_c_q && !adv_d);
      valid_d_q <= adv_d || (valid_d_q && !result_out_o.ready);
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (acc_a) begin
      opcode_a_q <= item_in_i.opcode;
      rate_a_q   <= item_in_i.sample_rate;
      ok_a_q     <= item_in_i.sample_ok;
    end
  end

  // Running-state update into the state/result register
  ftewma_update u_update (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv_b),
    .opcode_i      (opcode_a_q),
    .sample_rate_i (rate_a_q),
    .sample_ok_i   (ok_a_q),
    .cfg_i         (cfg_q),
    .res_o         (res_b)
  );

  // Volume divide alongside the carried fields
  ftewma_voldiv u_voldiv (
    .clk_i    (clk_i),
    .en_i     (adv_c),
    .accum_i  (res_b.volume_accum),
    .vol_ml_o (vol_c)
  );

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      res_c_q <= res_b;
    end
  end

  // Output register with the cutoff decisions
  always_ff @(posedge clk_i) begin
    if (adv_d) begin
      res_d_q   <= res_c_q;
      vol_d_q   <= vol_c;
      cut_vol_q <= (vol_c > cfg_q.volume_cutoff_ml);
      cut_low_q <= (vol_c > cfg_q.lowrate_min_volume_ml) &&
                   (res_c_q.peak_rate >= cfg_q.lowrate_min_peak) &&
                   (res_c_q.average_rate < cfg_q.lowrate_fall_rate);
    end
  end

  assign result_out_o.valid          = valid_d_q;
  assign result_out_o.rate_now       = res_d_q.rate_now;
  assign result_out_o.sample_bad     = res_d_q.sample_bad;
  assign result_out_o.average_rate   = res_d_q.average_rate;
  assign result_out_o.peak_rate      = res_d_q.peak_rate;
  assign result_out_o.volume_accum   = res_d_q.volume_accum;
  assign result_out_o.volume_ml      = vol_d_q;
  assign result_out_o.good_count     = res_d_q.good_count;
  assign result_out_o.bad_count      = res_d_q.bad_count;
  assign result_out_o.bad_run        = res_d_q.bad_run;
  assign result_out_o.inrange_count  = res_d_q.inrange_count;
  assign result_out_o.cutoff_volume  = cut_vol_q;
  assign result_out_o.cutoff_lowrate = cut_low_q;

  // Below one divisor the volume reads zero
  a_vol_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_d_q && (res_d_q.volume_accum < 32'(ftewma_pkg::VolDivisor)) |->
      (vol_d_q == '0))
    else $error("volume nonzero below one mL");

  // Large accumulators saturate the volume
  a_vol_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_d_q && (res_d_q.volume_accum >= ftewma_pkg::VolSatLimit) |->
      (vol_d_q == {ftewma_pkg::VolQuotW{1'b1}}))
    else $error("volume not saturated");

  // Input stalls only while every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_a |-> (valid_a_q && valid_b_q && valid_c_q && valid_d_q))
    else $error("stall with an empty stage");

endmodule

`default_nettype wire
